// ===== sv/acrfc_pkg.sv =====
package acrfc_pkg;

  localparam int unsigned FRAME_W = 48;

  localparam logic [47:0] BASE_WORD = 48'hA1826FFFFF62;
  localparam logic [47:0] W48_MASK  = 48'hFFFFFFFFFFFF;

  localparam logic [4:0] HDR_CODE  = 5'h14;
  localparam int unsigned HDR_POS  = 43;
  localparam int unsigned PWR_POS  = 39;
  localparam int unsigned FAN_POS  = 35;
  localparam int unsigned MODE_POS = 32;
  localparam int unsigned FLAG_F_POS = 29;
  localparam int unsigned TEMP_POS = 24;

  localparam logic [7:0] T_LOW_C  = 8'd17;
  localparam logic [7:0] T_HIGH_C = 8'd30;
  localparam logic [8:0] T_LOW_F  = 9'd62;
  localparam logic [8:0] F_ZERO   = 9'd32;

  localparam logic [2:0] MODE_FAN  = 3'd4;
  localparam logic [2:0] MODE_AUTO = 3'd2;

  localparam logic OP_ENCODE = 1'b0;
  localparam logic OP_DECODE = 1'b1;

  typedef logic [FRAME_W-1:0] frame_t;

  // Decoded settings carried from the parser to the result register.
  typedef struct packed {
    logic       ok;
    logic       power;
    logic [2:0] mode;
    logic [1:0] fan;
    logic [5:0] temp;
  } acrfc_fields_t;

  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = b[k];
    end
    return r;
  endfunction

  // Reflected byte sum of bytes 1..5, negated, reflected back.
  function automatic logic [7:0] frame_sum(input frame_t w);
    logic [7:0] acc;
    acc = '0;
    for (int k = 1; k <= 5; k++) begin
      acc = acc + flip8(w[8*k +: 8]);
    end
    return flip8(8'(8'd0 - acc));
  endfunction

  function automatic logic [2:0] fix_mode(input logic [2:0] m);
    return (m > MODE_FAN) ? MODE_AUTO : m;
  endfunction

endpackage

// ===== sv/acrfc_encode.sv =====
module acrfc_encode (
  input  logic               power,
  input  logic [2:0]         mode,
  input  logic [1:0]         fan,
  input  logic [7:0]         temp,
  output acrfc_pkg::frame_t  frame
);
  import acrfc_pkg::*;

  logic [7:0] t_clamp;
  logic [4:0] t_field;
  frame_t     w;

  always_comb begin
    if (temp < T_LOW_C) begin
      t_clamp = T_LOW_C;
    end else if (temp > T_HIGH_C) begin
      t_clamp = T_HIGH_C;
    end else begin
      t_clamp = temp;
    end
    t_field = 5'(t_clamp - T_LOW_C);

    w = BASE_WORD;
    w[MODE_POS +: 3]  = fix_mode(mode);
    w[FAN_POS +: 2]   = fan;
    w[PWR_POS]        = power;
    w[FLAG_F_POS]     = 1'b0;
    w[TEMP_POS +: 5]  = t_field;
    w[7:0]            = frame_sum(w);
    frame = w;
  end

endmodule

// ===== sv/acrfc_decode.sv =====
module acrfc_decode (
  input  acrfc_pkg::frame_t        frame,
  output acrfc_pkg::acrfc_fields_t fields
);
  import acrfc_pkg::*;

  logic [4:0]  tf;
  logic [5:0]  t_cels;
  logic [8:0]  f_scaled;
  logic [14:0] f_prod;
  logic        hdr_ok;
  logic        sum_ok;

  always_comb begin
    tf       = frame[TEMP_POS +: 5];
    t_cels   = 6'(tf) + 6'(T_LOW_C);
    // (F - 32) * 5 + 4, at most 309
    f_scaled = 9'(({4'd0, tf} + (T_LOW_F - F_ZERO)) * 9'd5 + 9'd4);
    // divide by 9: x * 57 / 512 is exact for x below 512
    f_prod   = 15'(f_scaled) * 15'd57;
    hdr_ok   = (frame[HDR_POS +: 5] == HDR_CODE);
    sum_ok   = (frame[7:0] == frame_sum(frame));

    fields = '0;
    if (hdr_ok && sum_ok) begin
      fields.ok    = 1'b1;
      fields.power = frame[PWR_POS];
      fields.mode  = fix_mode(frame[MODE_POS +: 3]);
      fields.fan   = frame[FAN_POS +: 2];
      fields.temp  = frame[FLAG_F_POS] ? f_prod[14:9] : t_cels;
    end
  end

endmodule

// ===== sv/ac_remote_frame_codec_top.sv =====
// Air-conditioner remote frame codec. Each item either builds a 48-bit
// state word from power, mode, fan and Celsius temperature (opcode 0; the
// temperature is clamped to 17..30, unknown modes go out as auto, and the
// word's complement is given alongside) or parses a received word
// (opcode 1; header and checksum are checked, fields unpacked, Fahrenheit
// converted to Celsius with rounding, everything zero on a failed check).
// The block is a two-register pipeline: an input register, then the pack,
// unpack and five-byte checksum logic, then the result register. It takes
// one item per cycle unless out_ready holds the output. An accepted item
// is captured in the input register and then moves into the result
// register, which drives the outputs; a stall holds it where it is. With
// out_ready held low it holds two items before in_ready drops.
module ac_remote_frame_codec_top (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic        in_power_in,
  input  logic [2:0]  in_mode_in,
  input  logic [1:0]  in_fan_in,
  input  logic [7:0]  in_temp_in,
  input  logic [47:0] in_frame_in,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [47:0] out_frame_out,
  output logic [47:0] out_frame_inverted,
  output logic        out_decode_ok,
  output logic        out_power_out,
  output logic [2:0]  out_mode_out,
  output logic [1:0]  out_fan_out,
  output logic [5:0]  out_temp_out
);
  import acrfc_pkg::*;

  // input register
  logic          s1_valid_r, s1_valid_nxt;
  logic          opcode_r;
  logic          power_r;
  logic [2:0]    mode_r;
  logic [1:0]    fan_r;
  logic [7:0]    temp_r;
  frame_t        frame_r;

  // result register
  logic          out_valid_r, out_valid_nxt;
  frame_t        frame_out_r;
  frame_t        frame_inv_r;
  acrfc_fields_t fields_r;

  frame_t        enc_frame;
  acrfc_fields_t dec_fields;

  logic          s2_ready;
  logic          s1_ready;
  logic          s1_load;
  logic          s2_load;

  // A stage takes a new item when it is empty or its item moves on.
  assign s2_ready = !out_valid_r || out_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;
  assign s1_load  = in_valid && s1_ready;
  assign s2_load  = s1_valid_r && s2_ready;

  always_comb begin
    s1_valid_nxt  = s1_load ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = s2_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      opcode_r <= in_opcode;
      power_r  <= in_power_in;
      mode_r   <= in_mode_in;
      fan_r    <= in_fan_in;
      temp_r   <= in_temp_in;
      frame_r  <= in_frame_in;
    end
  end

  acrfc_encode u_encode (
    .power (power_r),
    .mode  (mode_r),
    .fan   (fan_r),
    .temp  (temp_r),
    .frame (enc_frame)
  );

  acrfc_decode u_decode (
    .frame  (frame_r),
    .fields (dec_fields)
  );

  // Encode gives the word pair and zero fields; decode the reverse.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      if (opcode_r == OP_ENCODE) begin
        frame_out_r <= enc_frame;
        frame_inv_r <= (~enc_frame) & W48_MASK;
        fields_r    <= '0;
      end else begin
        frame_out_r <= '0;
        frame_inv_r <= '0;
        fields_r    <= dec_fields;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_frame_out      = frame_out_r;
  assign out_frame_inverted = frame_inv_r;
  assign out_decode_ok      = fields_r.ok;
  assign out_power_out      = fields_r.power;
  assign out_mode_out       = fields_r.mode;
  assign out_fan_out        = fields_r.fan;
  assign out_temp_out       = fields_r.temp;

`ifndef NO_ASSERTIONS
  a_dec_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && fields_r.ok |-> frame_out_r == '0 && frame_inv_r == '0)
    else $error("decode result carries a frame");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !fields_r.ok |->
      !fields_r.power && fields_r.mode == '0 && fields_r.fan == '0 &&
      fields_r.temp == '0)
    else $error("failed or encode result has nonzero fields");

  a_inv_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && frame_out_r != '0 |-> frame_inv_r == ~frame_out_r)
    else $error("complement word mismatch");

  a_hold_s1: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_ready |=> s1_valid_r && $stable(frame_r))
    else $error("stalled item lost from input register");
`endif

endmodule
